/* rtl/edge_glow_pixel_stream_assert.svh */
// Assertion macros for the edge glow pixel stream.
// Needs signals clk and arst_n in the scope that uses them.
`ifndef EDGE_GLOW_PIXEL_STREAM_ASSERT_SVH
`define EDGE_GLOW_PIXEL_STREAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define EGP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edge glow assertion failed");
// next-cycle implication
`define EGP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edge glow assertion failed");
`else
`define EGP_ASSERT_IMP(lbl, ante, cons)
`define EGP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/egp_pkg.sv */
// Package for the edge glow pixel stream: sizes, codes, state type and
// small arithmetic helpers. No dependencies.
package egp_pkg;

	localparam int MAX_WIDTH     = 2048;
	localparam int PIX_DEPTH     = 2 * MAX_WIDTH + 2;
	localparam int EDGE_DEPTH    = 2 * MAX_WIDTH + 3;
	localparam int AW            = $clog2(EDGE_DEPTH);
	localparam int W_BITS        = $clog2(MAX_WIDTH + 1);
	localparam int COL_BITS      = $clog2(MAX_WIDTH);
	localparam int H_BITS        = 13;
	localparam int ROW_BITS      = H_BITS + 1;
	localparam int POS_BITS      = ROW_BITS + W_BITS;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 13;

	// 1336965 = 255 * 5243: L*255/100 as one multiply and a shift by 19
	localparam int LUMA_OUT_MUL  = 1336965;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_TGT_LUMA  = 3'd1,
		REG_TGT_CB    = 3'd2,
		REG_TGT_CR    = 3'd3,
		REG_SCALE     = 3'd4,
		REG_WIDTH     = 3'd5,
		REG_HEIGHT    = 3'd6
	} cfg_idx_t;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_POS   = 11'b000_0000_0010,
		S_CHK   = 11'b000_0000_0100,
		S_RD    = 11'b000_0000_1000,
		S_CAP   = 11'b000_0001_0000,
		S_GRAD  = 11'b000_0010_0000,
		S_BLUR  = 11'b000_0100_0000,
		S_GAIN  = 11'b000_1000_0000,
		S_MIX   = 11'b001_0000_0000,
		S_DIV   = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} pix_t;

	// distance back from the newest item for window tap k (row major 3x3)
	function automatic logic [AW-1:0] tap_lookback(input logic [W_BITS-1:0] w,
			input logic [2:0] k);
		logic [AW-1:0] wd;
		wd = AW'(w);
		case (k)
			3'd0: tap_lookback = (wd << 1) + AW'(2);
			3'd1: tap_lookback = (wd << 1) + AW'(1);
			3'd2: tap_lookback = wd << 1;
			3'd3: tap_lookback = wd + AW'(2);
			3'd4: tap_lookback = wd + AW'(1);
			3'd5: tap_lookback = wd;
			3'd6: tap_lookback = AW'(2);
			3'd7: tap_lookback = AW'(1);
			default: tap_lookback = '0;
		endcase
	endfunction

	// ring address d entries behind wp
	function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] wp,
			input logic [AW-1:0] d, input logic [AW-1:0] depth);
		logic [AW:0] diff;
		diff = {1'b0, wp} - {1'b0, d};
		if (diff[AW])
			ring_back = AW'(diff + {1'b0, depth});
		else
			ring_back = AW'(diff);
	endfunction

	// position is not on the frame border
	function automatic logic interior_at(input logic [ROW_BITS-1:0] r,
			input logic [W_BITS-1:0] c, input logic [W_BITS-1:0] w,
			input logic [H_BITS-1:0] h);
		interior_at = (r != '0) && (c != '0)
			&& ({1'b0, r} + (ROW_BITS+1)'(2) <= (ROW_BITS+1)'(h))
			&& ({1'b0, c} + (W_BITS+1)'(2) <= (W_BITS+1)'(w));
	endfunction

	// lightness: Y*100 >> 8
	function automatic logic signed [9:0] lab_l(input logic [7:0] y);
		logic [14:0] t;
		t = 15'(y) * 15'(100);
		lab_l = $signed({3'b000, t[14:8]});
	endfunction

	// chroma axis: floor((c-128)*127 / 256)
	function automatic logic signed [9:0] lab_ab(input logic [7:0] c);
		logic signed [9:0]  d;
		logic signed [17:0] t;
		logic signed [17:0] s;
		d = $signed({2'b00, c}) - 10'sd128;
		t = 18'(d) * 18'sd127;
		s = t >>> 8;
		lab_ab = s[9:0];
	endfunction

	// x / 255 truncated toward zero, |x| below 65535
	function automatic logic signed [9:0] div255(input logic signed [19:0] x);
		logic [19:0] mag;
		logic [15:0] n;
		logic [16:0] t;
		logic signed [9:0] qs;
		mag = x[19] ? 20'(-x) : 20'(x);
		n   = mag[15:0];
		t   = 17'(n) + 17'(n >> 8) + 17'd1;
		qs  = $signed({1'b0, t[16:8]});
		div255 = x[19] ? -qs : qs;
	endfunction

	// clamp a small signed value to 0..255
	function automatic logic [7:0] clamp255(input logic signed [10:0] v);
		if (v < 0)
			clamp255 = 8'd0;
		else if (v > 11'sd255)
			clamp255 = 8'd255;
		else
			clamp255 = v[7:0];
	endfunction

endpackage

/* rtl/edge_glow_pixel_stream.sv */
// Edge glow pixel stream: 3x3 gradient edge map, box blur and colour blend.
// The input stalls while an item is processed: no new item is taken until the sequence
// returns to idle, after the four dual-port read slots of the line memories and, when a result
// is due, the blend arithmetic sequence and the output hand-off (which waits on output stall).
// Results follow their input pixel by 2*width+2 items. Async active-low reset clears
// control and config; line memories have no clearing pass and read as unknown until written.
`include "edge_glow_pixel_stream_assert.svh"

module edge_glow_pixel_stream import egp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [7:0]               in_luma,
	input  logic [7:0]               in_cb,
	input  logic [7:0]               in_cr,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               out_luma,
	output logic [7:0]               out_cb,
	output logic [7:0]               out_cr,
	output logic                     frame_end
);

	// config registers
	logic [7:0]        thresh_q, tgt_luma_q, tgt_cb_q, tgt_cr_q;
	logic [6:0]        scale_q;
	logic [11:0]       fwidth_q;
	logic [H_BITS-1:0] fheight_q;

	// control
	state_t              state_q;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [AW-1:0]       pix_wp_q, edge_wp_q;
	logic [1:0]          rd_q, rd_s1;
	logic                rdv_s1, out_valid_q;

	// per-item datapath
	logic                op_q;
	pix_t                cur_q, oldest_q;
	logic [POS_BITS-1:0] p_q, total_q;
	logic                qvalid_q, ovalid_q, oint_q, fend_q;
	logic [7:0]          lwin_q [8];
	logic [7:0]          ewin_q [9];
	logic [7:0]          blur_q, ei_q;
	logic signed [9:0]   l1_q, a1_q, b1_q, l2_q, a2_q, b2_q;
	logic signed [19:0]  prod_l_q, prod_a_q, prod_b_q;
	logic [7:0]          out_luma_q, out_cb_q, out_cr_q;
	logic                frame_end_q;

	// line memories
	pix_t       pix_mem  [PIX_DEPTH];
	logic [7:0] edge_mem [EDGE_DEPTH];
	pix_t       prd_a, prd_b;
	logic [7:0] erd_a, erd_b;

	logic [W_BITS-1:0] w_eff;
	logic [H_BITS-1:0] h_eff;
	logic              accept, out_free, load_out, rd_en, mem_we;
	logic [AW-1:0]     pa, pb, ea, eb;

	// effective geometry
	always_comb begin
		if (fwidth_q < 12'd3)
			w_eff = W_BITS'(3);
		else if (fwidth_q > 12'(MAX_WIDTH))
			w_eff = W_BITS'(MAX_WIDTH);
		else
			w_eff = W_BITS'(fwidth_q);
		h_eff = (fheight_q < H_BITS'(3)) ? H_BITS'(3) : fheight_q;
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == S_OUT) && out_free;
	assign rd_en    = (state_q == S_RD);
	assign mem_we   = (state_q == S_GRAD);

	// read addresses: two window taps per slot
	always_comb begin
		pa = ring_back(pix_wp_q, tap_lookback(w_eff, {rd_q, 1'b0}), AW'(PIX_DEPTH));
		pb = ring_back(pix_wp_q, tap_lookback(w_eff, {rd_q, 1'b1}), AW'(PIX_DEPTH));
		ea = ring_back(edge_wp_q, tap_lookback(w_eff, {rd_q, 1'b0}), AW'(EDGE_DEPTH));
		eb = ring_back(edge_wp_q, tap_lookback(w_eff, {rd_q, 1'b1}), AW'(EDGE_DEPTH));
	end

	// position flags of the window centre and the output pixel
	logic                c_ge1, c_ge2, q_ok, o_ok, o_int;
	logic [ROW_BITS-1:0] rq, ro;
	logic [W_BITS-1:0]   cq, co;
	always_comb begin
		c_ge1 = (col_q != '0);
		c_ge2 = (col_q >= COL_BITS'(2));
		rq = c_ge1 ? row_q - ROW_BITS'(1) : row_q - ROW_BITS'(2);
		cq = c_ge1 ? W_BITS'(col_q) - W_BITS'(1) : w_eff - W_BITS'(1);
		ro = c_ge2 ? row_q - ROW_BITS'(2) : row_q - ROW_BITS'(3);
		co = c_ge2 ? W_BITS'(col_q) - W_BITS'(2) : W_BITS'(col_q) + w_eff - W_BITS'(2);
		q_ok = ((row_q >= ROW_BITS'(2)) || ((row_q == ROW_BITS'(1)) && c_ge1))
			&& interior_at(rq, cq, w_eff, h_eff);
		o_ok = (row_q >= ROW_BITS'(3)) || ((row_q == ROW_BITS'(2)) && c_ge2);
		o_int = interior_at(ro, co, w_eff, h_eff);
	end

	// gradient and edge value
	logic signed [11:0] s [9];
	logic signed [11:0] gx, gy;
	logic [11:0]        ax, ay, grad;
	logic [7:0]         bval;
	always_comb begin
		for (int k = 0; k < 8; k++)
			s[k] = $signed({4'b0000, lwin_q[k]});
		s[8] = $signed({4'b0000, cur_q.luma});
		gx = s[0] - s[2] + ((s[3] - s[5]) <<< 1) + s[6] - s[8];
		gy = s[0] + (s[1] <<< 1) + s[2] - s[6] - (s[7] <<< 1) - s[8];
		ax = gx[11] ? 12'(-gx) : 12'(gx);
		ay = gy[11] ? 12'(-gy) : 12'(gy);
		grad = ax + ay;
		if (qvalid_q && (grad[11:2] > {2'b00, thresh_q}))
			bval = (grad > 12'd255) ? 8'd255 : grad[7:0];
		else
			bval = 8'd0;
	end

	// blur of the edge window
	logic [11:0] esum;
	logic [16:0] sum29;
	logic [7:0]  blur;
	always_comb begin
		esum = '0;
		for (int k = 0; k < 9; k++)
			esum = esum + 12'(ewin_q[k]);
		sum29 = 17'(esum) * 17'(29);
		if (!oint_q)
			blur = 8'd0;
		else if (sum29[16:8] > 9'd255)
			blur = 8'd255;
		else
			blur = sum29[15:8];
	end

	// gain
	logic [11:0] gain;
	logic [19:0] gprod;
	logic [7:0]  ei;
	always_comb begin
		gain  = 12'(scale_q) * 12'(26);
		gprod = 20'(blur_q) * 20'(gain);
		ei    = (gprod[19:8] > 12'd255) ? 8'd255 : gprod[15:8];
	end

	// blend products and final conversion
	logic signed [9:0]  es;
	logic signed [9:0]  l_new, a_new, b_new;
	logic [27:0]        ymul;
	logic [7:0]         y_fin, cb_fin, cr_fin;
	always_comb begin
		es    = $signed({2'b00, ei_q});
		l_new = l1_q + div255(prod_l_q);
		a_new = a1_q + div255(prod_a_q);
		b_new = b1_q + div255(prod_b_q);
		ymul  = 28'(l1_q[6:0]) * 28'(LUMA_OUT_MUL);
		if (l1_q < 0)
			y_fin = 8'd0;
		else if (ymul[27:19] > 9'd255)
			y_fin = 8'd255;
		else
			y_fin = ymul[26:19];
		cb_fin = clamp255(11'(a1_q) + 11'sd128);
		cr_fin = clamp255(11'(b1_q) + 11'sd128);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= 8'd15;
			tgt_luma_q <= 8'd210;
			tgt_cb_q   <= 8'd16;
			tgt_cr_q   <= 8'd146;
			scale_q    <= 7'd20;
			fwidth_q   <= 12'd1920;
			fheight_q  <= H_BITS'(1080);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_THRESHOLD: thresh_q   <= cfg_data[7:0];
				REG_TGT_LUMA:  tgt_luma_q <= cfg_data[7:0];
				REG_TGT_CB:    tgt_cb_q   <= cfg_data[7:0];
				REG_TGT_CR:    tgt_cr_q   <= cfg_data[7:0];
				REG_SCALE:     scale_q    <= cfg_data[6:0];
				REG_WIDTH:     fwidth_q   <= cfg_data[11:0];
				REG_HEIGHT:    fheight_q  <= cfg_data[H_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and position counters
	logic [W_BITS-1:0] col_inc;
	assign col_inc = W_BITS'(col_q) + W_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			pix_wp_q    <= '0;
			edge_wp_q   <= '0;
			rd_q        <= '0;
			rd_s1       <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= rd_en;
			rd_s1  <= rd_q;
			// result register: set on load, cleared once taken
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (W_BITS'(col_q) >= w_eff) begin
							col_q <= '0;
							row_q <= row_q + ROW_BITS'(1);
						end
						state_q <= S_POS;
					end
				end
				S_POS: state_q <= S_CHK;
				S_CHK: begin
					if (((op_q == OP_PIXEL) && (p_q >= total_q))
							|| ((op_q == OP_FLUSH) && (p_q < total_q)))
						state_q <= S_IDLE;
					else begin
						rd_q    <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					rd_q <= rd_q + 2'd1;
					if (rd_q == 2'd3)
						state_q <= S_CAP;
				end
				S_CAP: state_q <= S_GRAD;
				S_GRAD: begin
					pix_wp_q  <= (pix_wp_q == AW'(PIX_DEPTH - 1)) ? '0 : pix_wp_q + AW'(1);
					edge_wp_q <= (edge_wp_q == AW'(EDGE_DEPTH - 1)) ? '0 : edge_wp_q + AW'(1);
					if (col_inc >= w_eff) begin
						col_q <= '0;
						row_q <= row_q + ROW_BITS'(1);
					end else
						col_q <= col_inc[COL_BITS-1:0];
					state_q <= ovalid_q ? S_BLUR : S_IDLE;
				end
				S_BLUR: state_q <= S_GAIN;
				S_GAIN: state_q <= S_MIX;
				S_MIX:  state_q <= S_DIV;
				S_DIV:  state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (fend_q) begin
							col_q <= '0;
							row_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			cur_q <= (opcode == OP_FLUSH) ? pix_t'('0) : pix_t'({in_luma, in_cb, in_cr});
		end
		if (state_q == S_POS) begin
			p_q      <= POS_BITS'(row_q) * POS_BITS'(w_eff) + POS_BITS'(col_q);
			total_q  <= POS_BITS'(h_eff) * POS_BITS'(w_eff);
			qvalid_q <= q_ok;
			ovalid_q <= o_ok;
			oint_q   <= o_int;
		end
		if (state_q == S_CHK)
			fend_q <= p_q >= total_q + (POS_BITS'(w_eff) << 1) + POS_BITS'(1);
		// window capture in the cycle after each read slot
		if (rdv_s1) begin
			lwin_q[{rd_s1, 1'b0}] <= prd_a.luma;
			lwin_q[{rd_s1, 1'b1}] <= prd_b.luma;
			ewin_q[{1'b0, rd_s1, 1'b0}] <= erd_a;
			ewin_q[{1'b0, rd_s1, 1'b1}] <= erd_b;
			if (rd_s1 == 2'd0)
				oldest_q <= prd_a;
		end
		if (state_q == S_GRAD)
			ewin_q[8] <= bval;
		if (state_q == S_BLUR)
			blur_q <= blur;
		if (state_q == S_GAIN) begin
			ei_q <= ei;
			l1_q <= lab_l(oldest_q.luma);
			a1_q <= lab_ab(oldest_q.cb);
			b1_q <= lab_ab(oldest_q.cr);
			l2_q <= lab_l(tgt_luma_q);
			a2_q <= lab_ab(tgt_cb_q);
			b2_q <= lab_ab(tgt_cr_q);
		end
		if (state_q == S_MIX) begin
			prod_l_q <= 20'(l2_q - l1_q) * 20'(es);
			prod_a_q <= 20'(a2_q - a1_q) * 20'(es);
			prod_b_q <= 20'(b2_q - b1_q) * 20'(es);
		end
		if (state_q == S_DIV) begin
			l1_q <= l_new;
			a1_q <= a_new;
			b1_q <= b_new;
		end
		if (load_out) begin
			if (ei_q == 8'd0) begin
				out_luma_q <= oldest_q.luma;
				out_cb_q   <= oldest_q.cb;
				out_cr_q   <= oldest_q.cr;
			end else begin
				out_luma_q <= y_fin;
				out_cb_q   <= cb_fin;
				out_cr_q   <= cr_fin;
			end
			frame_end_q <= fend_q;
		end
	end

	// line memories: two registered reads, one write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			prd_a <= pix_mem[pa];
			prd_b <= pix_mem[pb];
			erd_a <= edge_mem[ea];
			erd_b <= edge_mem[eb];
		end
		if (mem_we) begin
			pix_mem[pix_wp_q]   <= cur_q;
			edge_mem[edge_wp_q] <= bval;
		end
	end

	assign out_valid = out_valid_q;
	assign out_luma  = out_luma_q;
	assign out_cb    = out_cb_q;
	assign out_cr    = out_cr_q;
	assign frame_end = frame_end_q;

	// checks
	`EGP_ASSERT_IMP(a_pix_wp_range, 1'b1, pix_wp_q < AW'(PIX_DEPTH))
	`EGP_ASSERT_IMP(a_edge_wp_range, 1'b1, edge_wp_q < AW'(EDGE_DEPTH))
	`EGP_ASSERT_NXT(a_frame_restart, load_out && fend_q, col_q == '0 && row_q == '0)

endmodule

/* sim/edge_glow_pixel_stream_tb.sv */
// Testbench for the edge glow pixel stream: random and directed frames, scoreboard check.
// Depends on egp_pkg and the edge_glow_pixel_stream RTL; self-contained otherwise.
`timescale 1ns / 100ps

module edge_glow_pixel_stream_tb;
	import egp_pkg::*;

	typedef struct {
		logic       op;
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} px_item_t;

	typedef struct {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
		logic       fend;
	} glow_px_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic                     opcode;
	logic [7:0]               in_luma;
	logic [7:0]               in_cb;
	logic [7:0]               in_cr;
	logic                     out_valid;
	logic                     out_stall;
	logic [7:0]               out_luma;
	logic [7:0]               out_cb;
	logic [7:0]               out_cr;
	logic                     frame_end;

	edge_glow_pixel_stream DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.in_luma(in_luma), .in_cb(in_cb), .in_cr(in_cr), .out_valid(out_valid),
		.out_stall(out_stall), .out_luma(out_luma), .out_cb(out_cb), .out_cr(out_cr),
		.frame_end(frame_end)
	);

	// shadow copy of the registers
	int unsigned thr_q, tl_q, tcb_q, tcr_q, gain_q, fw_q, fh_q;

	// shadow copy of the stream state
	int unsigned pix_hist[PIX_DEPTH];
	int unsigned edge_hist[EDGE_DEPTH];
	int unsigned col_q, row_q, pix_wp, edge_wp;

	px_item_t pending_px[$];
	glow_px_t glow_due[$];
	int errors, results_seen, frames_done, edge_hits, pixels_sent;
	int in_gap, out_hold;
	bit bursty;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned ring_idx(int unsigned wp, int unsigned d,
			int unsigned depth);
		return (wp + depth - d) % depth;
	endfunction

	function automatic int unsigned tap_dist(int unsigned w, int k);
		int dr, dc;
		dr = k / 3 - 1;
		dc = k % 3 - 1;
		return int'(w) + 1 - dr * int'(w) - dc;
	endfunction

	function automatic bit is_interior(int unsigned pos, int unsigned w, int unsigned h);
		int unsigned r, c;
		r = pos / w;
		c = pos % w;
		return r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w;
	endfunction

	function automatic int clip8(int v);
		return v < 0 ? 0 : (v > 255 ? 255 : v);
	endfunction

	// advance the shadow stream by one transfer and queue the pixel it releases
	task automatic predict_glow(input logic op, input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr);
		int unsigned w, h, p, total, cur, oldest, bval, sum, blur, ei, o;
		int ys[9];
		int gx, gy, grad, e, l2, a2, b2, l1, a1, b1, yy, ccb, ccr;
		glow_px_t r;
		w = fw_q < 3 ? 3 : (fw_q > MAX_WIDTH ? MAX_WIDTH : fw_q);
		h = fh_q < 3 ? 3 : fh_q;
		if (col_q >= w) begin
			col_q = 0;
			row_q++;
		end
		p = row_q * w + col_q;
		total = w * h;
		if (op == OP_PIXEL && p >= total) return;
		if (op == OP_FLUSH && p < total) return;
		cur = op == OP_PIXEL ? {8'd0, y, cb, cr} : 0;
		for (int k = 0; k < 9; k++) begin
			if (tap_dist(w, k) == 0)
				ys[k] = cur >> 16;
			else
				ys[k] = (pix_hist[ring_idx(pix_wp, tap_dist(w, k), PIX_DEPTH)] >> 16) & 8'hFF;
		end
		bval = 0;
		if (p >= w + 1 && is_interior(p - w - 1, w, h)) begin
			gx = ys[0] - ys[2] + 2 * (ys[3] - ys[5]) + ys[6] - ys[8];
			gy = ys[0] + 2 * ys[1] + ys[2] - ys[6] - 2 * ys[7] - ys[8];
			grad = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			if ((grad * 255) / 1020 > int'(thr_q))
				bval = grad > 255 ? 255 : grad;
		end
		oldest = pix_hist[ring_idx(pix_wp, 2 * w + 2, PIX_DEPTH)];
		pix_hist[pix_wp] = cur;
		pix_wp = (pix_wp + 1) % PIX_DEPTH;
		edge_hist[edge_wp] = bval;
		sum = 0;
		for (int k = 0; k < 9; k++)
			sum += edge_hist[ring_idx(edge_wp, tap_dist(w, k), EDGE_DEPTH)];
		edge_wp = (edge_wp + 1) % EDGE_DEPTH;
		col_q++;
		if (col_q >= w) begin
			col_q = 0;
			row_q++;
		end
		if (p < 2 * w + 2) return;
		o = p - 2 * w - 2;
		yy = (oldest >> 16) & 8'hFF;
		ccb = (oldest >> 8) & 8'hFF;
		ccr = oldest & 8'hFF;
		blur = 0;
		if (is_interior(o, w, h)) begin
			blur = (sum * 29) >> 8;
			if (blur > 255) blur = 255;
		end
		ei = (blur * gain_q * 26) >> 8;
		if (ei > 255) ei = 255;
		r.luma = 8'(yy);
		r.cb = 8'(ccb);
		r.cr = 8'(ccr);
		// blend toward the glow colour in the scaled lightness/chroma space
		if (ei > 0) begin
			e = ei;
			l2 = (int'(tl_q) * 100) >> 8;
			a2 = ((int'(tcb_q) - 128) * 127) >>> 8;
			b2 = ((int'(tcr_q) - 128) * 127) >>> 8;
			l1 = (yy * 100) >> 8;
			a1 = ((ccb - 128) * 127) >>> 8;
			b1 = ((ccr - 128) * 127) >>> 8;
			l1 += ((l2 - l1) * e) / 255;
			a1 += ((a2 - a1) * e) / 255;
			b1 += ((b2 - b1) * e) / 255;
			r.luma = 8'(clip8((l1 * 255) / 100));
			r.cb = 8'(clip8(a1 + 128));
			r.cr = 8'(clip8(b1 + 128));
			edge_hits++;
		end
		r.fend = o + 1 >= total;
		if (r.fend) begin
			col_q = 0;
			row_q = 0;
		end
		glow_due.push_back(r);
	endtask

	// input driver: one transfer per item, random gap after each unless bursty
	always @(posedge clk or negedge arst_n) begin
		px_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_PIXEL;
			in_luma <= '0;
			in_cb <= '0;
			in_cr <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_glow(opcode, in_luma, in_cb, in_cr);
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_px.size() > 0) begin
					it = pending_px.pop_front();
					opcode <= it.op;
					in_luma <= it.luma;
					in_cb <= it.cb;
					in_cr <= it.cr;
					in_valid <= 1'b1;
					in_gap <= bursty ? 0 : int'($urandom_range(0, 5));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compare each transfer against the oldest prediction;
	// after each transfer a random hold (none when bursty) stalls the next result while it is offered
	always @(posedge clk or negedge arst_n) begin
		glow_px_t g;
		int hold_n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (frame_end) frames_done++;
				if (glow_due.size() == 0) begin
					$display("%0t: unexpected pixel luma=%0d cb=%0d cr=%0d fend=%0b",
						$time, out_luma, out_cb, out_cr, frame_end);
					errors++;
				end else begin
					g = glow_due.pop_front();
					if (out_luma !== g.luma) begin
						$display("%0t: out_luma exp %0d got %0d", $time, g.luma, out_luma);
						errors++;
					end
					if (out_cb !== g.cb) begin
						$display("%0t: out_cb exp %0d got %0d", $time, g.cb, out_cb);
						errors++;
					end
					if (out_cr !== g.cr) begin
						$display("%0t: out_cr exp %0d got %0d", $time, g.cr, out_cr);
						errors++;
					end
					if (frame_end !== g.fend) begin
						$display("%0t: frame_end exp %0b got %0b", $time, g.fend, frame_end);
						errors++;
					end
				end
				hold_n = bursty ? 0 : int'($urandom_range(0, 5));
				out_hold <= hold_n;
				out_stall <= hold_n > 0;
			end else if (out_valid && out_hold > 0) begin
				out_hold <= out_hold - 1;
				out_stall <= out_hold > 1;
			end
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_q = val & 8'hFF;
			REG_TGT_LUMA:  tl_q = val & 8'hFF;
			REG_TGT_CB:    tcb_q = val & 8'hFF;
			REG_TGT_CR:    tcr_q = val & 8'hFF;
			REG_SCALE:     gain_q = val & 7'h7F;
			REG_WIDTH:     fw_q = val & 12'hFFF;
			REG_HEIGHT:    fh_q = val & 13'h1FFF;
			default: ;
		endcase
	endtask

	task automatic set_all(input int unsigned thr, input int unsigned tl, input int unsigned tcb,
			input int unsigned tcr, input int unsigned gain, input int unsigned fw,
			input int unsigned fh);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_TGT_LUMA, tl);
		write_reg(REG_TGT_CB, tcb);
		write_reg(REG_TGT_CR, tcr);
		write_reg(REG_SCALE, gain);
		write_reg(REG_WIDTH, fw);
		write_reg(REG_HEIGHT, fh);
	endtask

	function automatic px_item_t make_px(input int style);
		px_item_t it;
		it.op = OP_PIXEL;
		case (style)
			0: it.luma = 8'($urandom_range(0, 255));
			1: it.luma = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: it.luma = 8'(120 + $urandom_range(0, 12));
		endcase
		it.cb = 8'($urandom_range(0, 255));
		it.cr = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// queue one frame plus its drain ticks; optionally slip in ignored items
	task automatic queue_frame(input int style, input bit stray);
		int unsigned w, h;
		px_item_t fl;
		w = fw_q < 3 ? 3 : (fw_q > MAX_WIDTH ? MAX_WIDTH : fw_q);
		h = fh_q < 3 ? 3 : fh_q;
		fl.op = OP_FLUSH;
		fl.luma = 8'($urandom_range(0, 255));
		fl.cb = 8'($urandom_range(0, 255));
		fl.cr = 8'($urandom_range(0, 255));
		for (int i = 0; i < w * h; i++) begin
			if (stray && i == w * h - 1) pending_px.push_back(fl);
			pending_px.push_back(make_px(style));
			pixels_sent++;
		end
		for (int i = 0; i < 2 * w + 2; i++) begin
			pending_px.push_back(fl);
			if (stray && i == 0) pending_px.push_back(make_px(0));
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_px.size() != 0 || in_valid || glow_due.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		px_item_t it;
		errors = 0;
		results_seen = 0;
		frames_done = 0;
		edge_hits = 0;
		pixels_sent = 0;
		bursty = 1'b0;
		thr_q = 15; tl_q = 210; tcb_q = 16; tcr_q = 146;
		gain_q = 20; fw_q = 1920; fh_q = 1080;
		col_q = 0; row_q = 0; pix_wp = 0; edge_wp = 0;
		foreach (pix_hist[i]) pix_hist[i] = 0;
		foreach (edge_hist[i]) edge_hist[i] = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: smallest frame, field extremes, strongest gain, stray items
		set_all(0, 255, 0, 255, 127, 3, 3);
		it.op = OP_PIXEL;
		for (int i = 0; i < 9; i++) begin
			it.luma = (i % 2) ? 8'd255 : 8'd0;
			it.cb = (i % 3 == 0) ? 8'd0 : 8'd255;
			it.cr = (i % 3 == 1) ? 8'd0 : 8'd255;
			if (i == 4) it.luma = 8'd255;
			pending_px.push_back(it);
			pixels_sent++;
		end
		it.op = OP_FLUSH;
		pending_px.insert(5, it);
		for (int i = 0; i < 8; i++) begin
			pending_px.push_back(it);
			if (i == 2) begin
				it.op = OP_PIXEL;
				pending_px.push_back(it);
				it.op = OP_FLUSH;
			end
		end
		wait_idle();
		// zero gain passes everything; widths below range clamp up, height zero too
		set_all(255, 0, 255, 0, 0, 1, 0);
		queue_frame(1, 1'b0);
		wait_idle();
		set_all(0, 0, 128, 128, 100, 4, 4);
		queue_frame(1, 1'b1);
		wait_idle();

		// random frames, mostly small geometry
		while (pixels_sent < 400) begin
			bursty = $urandom_range(0, 3) == 0;
			set_all($urandom_range(0, 3) == 0 ? $urandom_range(0, 1) * 255 : $urandom_range(0, 60),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 127), $urandom_range(0, 7) == 0 ? $urandom_range(0, 2)
				: $urandom_range(3, 12), $urandom_range(0, 7) == 0 ? $urandom_range(0, 2)
				: $urandom_range(3, 8));
			queue_frame($urandom_range(0, 2), $urandom_range(0, 3) == 0);
			wait_idle();
		end

		$display("covered %0d pixels in %0d frames, %0d results, %0d blended by edges",
			pixels_sent, frames_done, results_seen, edge_hits);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* edge_glow_pixel_stream.f */
+incdir+rtl
rtl/egp_pkg.sv
rtl/edge_glow_pixel_stream.sv
sim/edge_glow_pixel_stream_tb.sv
